/* rtl/ksl_pkg.sv */
// types, constants and lookup functions shared by the keyword/symbol lexer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ksl_pkg;

   localparam int POS_BITS   = 16;
   localparam int LEN_BITS   = 16;
   localparam int CODE_BITS  = 5;
   localparam int WORD_DEPTH = 11;
   localparam int WIDX_BITS  = 4;
   localparam int KW_NUM     = 21;

   localparam int FIFO_DEPTH = 4;
   localparam int FPTR_BITS  = 2;
   localparam int FCNT_BITS  = 3;

   localparam logic [LEN_BITS-1:0]  LEN_MAX    = '1;
   localparam logic [CODE_BITS-1:0] SLASH_CODE = 5'd12;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_A_LO  = 8'h61;
   localparam logic [7:0] CH_Z_LO  = 8'h7A;
   localparam logic [7:0] CH_CASE  = 8'h20;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_SLASH,
      MODE_LINE,
      MODE_BLOCK,
      MODE_BSTAR,
      MODE_STRING,
      MODE_INT,
      MODE_IDENT
   } lex_mode_type;

   typedef enum logic [2:0] {
      KIND_KEYWORD,
      KIND_SYMBOL,
      KIND_INTEGER,
      KIND_STRING,
      KIND_IDENT,
      KIND_COMMENT,
      KIND_ERROR,
      KIND_EOF
   } tok_kind_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      tok_kind_type          token_kind;
      logic [CODE_BITS-1:0]  token_code;
      logic [POS_BITS-1:0]   token_start;
      logic [LEN_BITS-1:0]   token_length;
      logic                  last_of_run;
   } rsp_type;

   typedef struct packed {
      logic                 hit;
      logic [CODE_BITS-1:0] code;
   } match_type;

   function automatic logic [WIDX_BITS-1:0] kw_len(input int idx);
      logic [WIDX_BITS-1:0] l;
      case (idx)
         0, 1:                    l = 4'd2;
         2, 3, 4:                 l = 4'd3;
         5, 6, 7, 8, 9, 10:       l = 4'd4;
         11, 12, 13, 14:          l = 4'd5;
         15, 16, 17:              l = 4'd6;
         18:                      l = 4'd7;
         19:                      l = 4'd8;
         default:                 l = 4'd11;
      endcase
      return l;
   endfunction

   // keyword text, right aligned, last character in the low byte
   function automatic logic [8*WORD_DEPTH-1:0] kw_text(input int idx);
      logic [8*WORD_DEPTH-1:0] t;
      case (idx)
         0:       t = 88'("do");
         1:       t = 88'("if");
         2:       t = 88'("int");
         3:       t = 88'("let");
         4:       t = 88'("var");
         5:       t = 88'("char");
         6:       t = 88'("else");
         7:       t = 88'("null");
         8:       t = 88'("this");
         9:       t = 88'("true");
         10:      t = 88'("void");
         11:      t = 88'("class");
         12:      t = 88'("false");
         13:      t = 88'("field");
         14:      t = 88'("while");
         15:      t = 88'("method");
         16:      t = 88'("return");
         17:      t = 88'("static");
         18:      t = 88'("boolean");
         19:      t = 88'("function");
         default: t = 88'("constructor");
      endcase
      return t;
   endfunction

   // parallel compare of the buffered word against every keyword
   function automatic match_type kw_lookup(input logic [WORD_DEPTH-1:0][7:0] word,
                                           input logic [LEN_BITS-1:0] len);
      match_type               m;
      logic [8*WORD_DEPTH-1:0] txt;
      int                      kl;
      int                      bi;
      logic                    eq;
      m = '0;
      for (int i = 0; i < KW_NUM; i++) begin
         txt = kw_text(i);
         kl  = int'(kw_len(i));
         eq  = (len == LEN_BITS'(kl));
         for (int j = 0; j < WORD_DEPTH; j++) begin
            bi = (j < kl) ? (kl - 1 - j) : 0;
            if (j < kl && word[j] != txt[8*bi +: 8]) begin
               eq = 1'b0;
            end
         end
         if (eq && !m.hit) begin
            m.hit  = 1'b1;
            m.code = CODE_BITS'(i);
         end
      end
      return m;
   endfunction

   function automatic match_type sym_lookup(input logic [7:0] c);
      match_type m;
      m.hit = 1'b1;
      case (c)
         8'h7B:   m.code = 5'd0;   // {
         8'h7D:   m.code = 5'd1;   // }
         8'h28:   m.code = 5'd2;   // (
         8'h29:   m.code = 5'd3;   // )
         8'h5B:   m.code = 5'd4;   // [
         8'h5D:   m.code = 5'd5;   // ]
         8'h2E:   m.code = 5'd6;   // .
         8'h2C:   m.code = 5'd7;   // ,
         8'h3B:   m.code = 5'd8;   // ;
         8'h2B:   m.code = 5'd9;   // +
         8'h2D:   m.code = 5'd10;  // -
         8'h2A:   m.code = 5'd11;  // *
         8'h2F:   m.code = 5'd12;  // /
         8'h26:   m.code = 5'd13;  // &
         8'h7C:   m.code = 5'd14;  // |
         8'h3C:   m.code = 5'd15;  // <
         8'h3E:   m.code = 5'd16;  // >
         8'h3D:   m.code = 5'd17;  // =
         8'h7E:   m.code = 5'd18;  // ~
         default: begin
            m.hit  = 1'b0;
            m.code = '0;
         end
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

/* rtl/keyword_symbol_lexer.sv */
// keyword/symbol lexer top level: byte scanner, keyword compare and result queue
// depends on ksl_pkg
`timescale 1ns / 1ps
`default_nettype none

// Streaming tokenizer taking one source byte per req item and returning tokens
// (kind, code, start offset, length) on the rsp channel. A byte is taken every
// cycle while the result queue has room for two tokens; the scanner state and
// the 11-byte word buffer update at the edge where the byte is accepted, and
// the tokens it closes (none, one or two, written together) go into the 4-entry
// result queue, so the input runs at one byte per cycle while that room lasts
// and the rsp port at one token per cycle while rsp_ready is high.
// Keyword matching is a parallel compare against all 21 keywords.
// The end-of-file token (byte 0 or end_of_input) returns the block to offset 0.
module keyword_symbol_lexer import ksl_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   lex_mode_type                  mode_ff, mode_in;
   logic [LEN_BITS-1:0]           len_ff, len_in;
   logic [POS_BITS-1:0]           start_ff, start_in;
   logic [POS_BITS-1:0]           pos_ff, pos_in;
   logic [WORD_DEPTH-1:0][7:0]    wbuf_ff;

   rsp_type                       fifo_ff [FIFO_DEPTH];
   logic [FPTR_BITS-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [FPTR_BITS-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [FCNT_BITS-1:0]          cnt_ff, cnt_in;

   logic                          req_fire, rsp_fire;
   logic [7:0]                    c, lower;
   logic                          is_digit, is_letter, is_word;
   logic [POS_BITS-1:0]           pos_inc;
   logic [LEN_BITS-1:0]           len_bump;
   match_type                     sym, kw;

   logic                          id_v, id_wr, id_eof;
   rsp_type                       id_item;
   lex_mode_type                  id_mode;
   logic [POS_BITS-1:0]           id_start;
   logic [LEN_BITS-1:0]           id_len;

   logic                          pre_v, sec_v, do_idle, eof_hit;
   rsp_type                       pre_item, sec_item, word_item;
   logic                          wb_we;
   logic [WIDX_BITS-1:0]          wb_idx;
   logic [7:0]                    wb_data;

   logic [1:0]                    push_n;
   rsp_type                       slot0, slot1;

   assign req_fire    = req_valid && req_ready;
   assign rsp_fire    = rsp_valid && rsp_ready;
   assign req_ready   = cnt_ff <= FCNT_BITS'(FIFO_DEPTH - 2);
   assign rsp_valid   = cnt_ff != '0;
   assign rsp_payload = fifo_ff[rd_ptr_ff];

   // scanner next state and the tokens closed by this byte
   always_comb begin
      c         = req_payload.char_code;
      lower     = c | CH_CASE;
      is_digit  = (c >= CH_0) && (c <= CH_9);
      is_letter = (lower >= CH_A_LO) && (lower <= CH_Z_LO);
      is_word   = is_digit || is_letter || (c == CH_UNDER);
      pos_inc   = pos_ff + 1'b1;
      len_bump  = (len_ff == LEN_MAX) ? len_ff : len_ff + 1'b1;
      sym       = sym_lookup(c);
      kw        = kw_lookup(wbuf_ff, len_ff);

      // byte seen between tokens
      id_v                 = 1'b0;
      id_item              = '0;
      id_item.token_start  = pos_ff;
      id_item.token_length = LEN_BITS'(1);
      id_mode              = MODE_IDLE;
      id_start             = start_ff;
      id_len               = len_ff;
      id_wr                = 1'b0;
      id_eof               = 1'b0;
      if (c == CH_NUL) begin
         id_v                 = 1'b1;
         id_item.token_kind   = KIND_EOF;
         id_item.token_length = '0;
         id_eof               = 1'b1;
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
         id_v = 1'b0;
      end else if (c == CH_SLASH) begin
         id_mode  = MODE_SLASH;
         id_start = pos_ff;
         id_len   = LEN_BITS'(1);
      end else if (c == CH_QUOTE) begin
         id_mode  = MODE_STRING;
         id_start = pos_inc;
         id_len   = '0;
      end else if (is_digit) begin
         id_mode  = MODE_INT;
         id_start = pos_ff;
         id_len   = LEN_BITS'(1);
      end else if (c == CH_UNDER || is_letter) begin
         id_mode  = MODE_IDENT;
         id_start = pos_ff;
         id_len   = LEN_BITS'(1);
         id_wr    = 1'b1;
      end else if (sym.hit) begin
         id_v               = 1'b1;
         id_item.token_kind = KIND_SYMBOL;
         id_item.token_code = sym.code;
      end else begin
         id_v               = 1'b1;
         id_item.token_kind = KIND_ERROR;
      end

      word_item              = '0;
      word_item.token_kind   = kw.hit ? KIND_KEYWORD : KIND_IDENT;
      word_item.token_code   = kw.hit ? kw.code : '0;
      word_item.token_start  = start_ff;
      word_item.token_length = len_ff;

      pre_v                 = 1'b0;
      pre_item              = '0;
      pre_item.token_start  = start_ff;
      pre_item.token_length = len_ff;
      sec_v                 = 1'b0;
      sec_item              = '0;
      do_idle               = 1'b0;
      eof_hit               = 1'b0;
      mode_in               = mode_ff;
      start_in              = start_ff;
      len_in                = len_ff;
      pos_in                = pos_inc;
      wb_we                 = 1'b0;
      wb_idx                = len_ff[WIDX_BITS-1:0];
      wb_data               = c;

      if (req_payload.end_of_input) begin
         pos_in = pos_ff;
         pre_v  = 1'b1;
         case (mode_ff)
            MODE_SLASH: begin
               pre_item.token_kind   = KIND_SYMBOL;
               pre_item.token_code   = SLASH_CODE;
               pre_item.token_length = LEN_BITS'(1);
            end
            MODE_LINE:   pre_item.token_kind = KIND_COMMENT;
            MODE_BLOCK,
            MODE_BSTAR,
            MODE_STRING: pre_item.token_kind = KIND_ERROR;
            MODE_INT:    pre_item.token_kind = KIND_INTEGER;
            MODE_IDENT:  pre_item = word_item;
            default:     pre_v = 1'b0;
         endcase
         sec_v                = 1'b1;
         sec_item.token_kind  = KIND_EOF;
         sec_item.token_start = pos_ff;
         eof_hit              = 1'b1;
      end else begin
         case (mode_ff)
            MODE_SLASH: begin
               if (c == CH_SLASH) begin
                  mode_in = MODE_LINE;
                  len_in  = LEN_BITS'(2);
               end else if (c == CH_STAR) begin
                  mode_in = MODE_BLOCK;
                  len_in  = LEN_BITS'(2);
               end else begin
                  pre_v                 = 1'b1;
                  pre_item.token_kind   = KIND_SYMBOL;
                  pre_item.token_code   = SLASH_CODE;
                  pre_item.token_length = LEN_BITS'(1);
                  do_idle               = 1'b1;
               end
            end
            MODE_LINE: begin
               if (c == CH_LF || c == CH_CR || c == CH_NUL) begin
                  pre_v               = 1'b1;
                  pre_item.token_kind = KIND_COMMENT;
                  do_idle             = 1'b1;
               end else begin
                  len_in = len_bump;
               end
            end
            MODE_BLOCK, MODE_BSTAR: begin
               if (c == CH_NUL) begin
                  pre_v               = 1'b1;
                  pre_item.token_kind = KIND_ERROR;
                  do_idle             = 1'b1;
               end else if (mode_ff == MODE_BSTAR && c == CH_SLASH) begin
                  pre_v                 = 1'b1;
                  pre_item.token_kind   = KIND_COMMENT;
                  pre_item.token_length = len_bump;
                  len_in                = len_bump;
                  mode_in               = MODE_IDLE;
               end else begin
                  len_in  = len_bump;
                  mode_in = (c == CH_STAR) ? MODE_BSTAR : MODE_BLOCK;
               end
            end
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  pre_v               = 1'b1;
                  pre_item.token_kind = KIND_STRING;
                  mode_in             = MODE_IDLE;
               end else if (c == CH_LF || c == CH_NUL) begin
                  pre_v               = 1'b1;
                  pre_item.token_kind = KIND_ERROR;
                  do_idle             = 1'b1;
               end else begin
                  len_in = len_bump;
               end
            end
            MODE_INT: begin
               if (is_digit) begin
                  len_in = len_bump;
               end else begin
                  pre_v               = 1'b1;
                  pre_item.token_kind = KIND_INTEGER;
                  do_idle             = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (is_word) begin
                  wb_we  = len_ff < LEN_BITS'(WORD_DEPTH);
                  len_in = len_bump;
               end else begin
                  pre_v    = 1'b1;
                  pre_item = word_item;
                  do_idle  = 1'b1;
               end
            end
            default: do_idle = 1'b1;
         endcase

         if (do_idle) begin
            mode_in  = id_mode;
            start_in = id_start;
            len_in   = id_len;
            sec_v    = id_v;
            sec_item = id_item;
            eof_hit  = id_eof;
            if (id_wr) begin
               wb_we  = 1'b1;
               wb_idx = '0;
            end
         end
      end

      // end of file returns the scanner to its reset state
      if (eof_hit) begin
         mode_in  = MODE_IDLE;
         start_in = '0;
         len_in   = '0;
         pos_in   = '0;
      end
   end

   // pack the closed tokens into queue slots, flagging the last one
   always_comb begin
      push_n = {1'b0, pre_v} + {1'b0, sec_v};
      slot0  = pre_v ? pre_item : sec_item;
      slot1  = sec_item;
      slot0.last_of_run = (push_n == 2'd1);
      slot1.last_of_run = 1'b1;
      if (!req_fire) begin
         push_n = '0;
      end
      rd_ptr_in = rsp_fire ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + FPTR_BITS'(push_n);
      cnt_in    = cnt_ff + FCNT_BITS'(push_n) - FCNT_BITS'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         len_ff    <= '0;
         start_ff  <= '0;
         pos_ff    <= '0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (req_fire) begin
            mode_ff  <= mode_in;
            len_ff   <= len_in;
            start_ff <= start_in;
            pos_ff   <= pos_in;
         end
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && wb_we) begin
         wbuf_ff[wb_idx] <= wb_data;
      end
      if (push_n != '0) begin
         fifo_ff[wr_ptr_ff] <= slot0;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + 1'b1] <= slot1;
      end
   end

endmodule

`default_nettype wire

/* rtl/ksl_checker.sv */
// port-level assertions for the keyword/symbol lexer, bound to the top level
// depends on ksl_pkg and keyword_symbol_lexer
`timescale 1ns / 1ps
`default_nettype none

module ksl_checker import ksl_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_payload
);

   // a waiting token holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp item changed while stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // end of file closes the run and has no length
   a_eof_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.token_kind == KIND_EOF |->
         rsp_payload.token_length == '0 && rsp_payload.last_of_run)
      else $error("bad end-of-file token");

   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.token_kind != KIND_KEYWORD &&
         rsp_payload.token_kind != KIND_SYMBOL |-> rsp_payload.token_code == '0)
      else $error("nonzero code on a token without one");

   a_symbol_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.token_kind == KIND_SYMBOL |->
         rsp_payload.token_length == LEN_BITS'(1) && rsp_payload.token_code <= 5'd18)
      else $error("bad symbol token");

endmodule

bind keyword_symbol_lexer ksl_checker u_ksl_checker (.*);

`default_nettype wire

/* dv/tb_keyword_symbol_lexer.sv */
// testbench for keyword_symbol_lexer: random source-like byte streams, token prediction
// and in-order checking of every token. depends on ksl_pkg and rtl/keyword_symbol_lexer
`timescale 1ns / 1ps

module tb_keyword_symbol_lexer;
   import ksl_pkg::*;

   localparam int PHASE_BYTES = 450;
   localparam int HOLD_AFTER  = 100;
   localparam int HOLD_CYCLES = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   keyword_symbol_lexer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // token table in keyword code order
   string keyword_names [KW_NUM] = '{
      "do", "if", "int", "let", "var", "char", "else", "null", "this", "true",
      "void", "class", "false", "field", "while", "method", "return", "static",
      "boolean", "function", "constructor"};
   string symbol_chars = "{}()[].,;+-*/&|<>=~";

   req_type pending_bytes [$];
   rsp_type expected_tokens [$];
   rsp_type step_tokens [$];
   int      bytes_queued = 0;
   int      bytes_accepted = 0;
   int      sender_idle_pct = 0;
   int      receiver_stall_pct = 0;
   int      mismatch_count = 0;
   int      hold_left = 0;
   bit      hold_done = 1'b0;

   // scanner state of the predictor
   lex_mode_type        lx_mode = MODE_IDLE;
   logic [7:0]          lx_word [WORD_DEPTH];
   logic [LEN_BITS-1:0] lx_len = '0;
   logic [POS_BITS-1:0] lx_start = '0;
   logic [POS_BITS-1:0] lx_pos = '0;
   bit                  lx_eof;

   function automatic void lex_clear();
      lx_mode  = MODE_IDLE;
      for (int i = 0; i < WORD_DEPTH; i++) lx_word[i] = 8'h00;
      lx_len   = '0;
      lx_start = '0;
      lx_pos   = '0;
   endfunction

   function automatic void add_token(tok_kind_type kind, int code,
                                     logic [POS_BITS-1:0] start,
                                     logic [LEN_BITS-1:0] len);
      rsp_type t;
      t.token_kind   = kind;
      t.token_code   = CODE_BITS'(code);
      t.token_start  = start;
      t.token_length = len;
      t.last_of_run  = 1'b0;
      step_tokens.insert(step_tokens.size(), t);
   endfunction

   function automatic void grow_lexeme();
      if (lx_len != LEN_MAX) lx_len = lx_len + 1'b1;
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      logic [7:0] l;
      l = c | CH_CASE;
      return l >= CH_A_LO && l <= CH_Z_LO;
   endfunction

   function automatic int keyword_index();
      bit same;
      if (lx_len > WORD_DEPTH) return -1;
      for (int i = 0; i < KW_NUM; i++) begin
         if (keyword_names[i].len() == int'(lx_len)) begin
            same = 1'b1;
            for (int j = 0; j < keyword_names[i].len(); j++) begin
               if (keyword_names[i][j] != lx_word[j]) same = 1'b0;
            end
            if (same) return i;
         end
      end
      return -1;
   endfunction

   function automatic void close_word();
      int k;
      k = keyword_index();
      if (k >= 0) add_token(KIND_KEYWORD, k, lx_start, lx_len);
      else add_token(KIND_IDENT, 0, lx_start, lx_len);
   endfunction

   function automatic void start_byte(logic [7:0] c, logic [POS_BITS-1:0] p);
      int s;
      lx_mode = MODE_IDLE;
      s = -1;
      for (int i = 0; i < symbol_chars.len(); i++) begin
         if (symbol_chars[i] == c && s < 0) s = i;
      end
      if (c == CH_NUL) begin
         add_token(KIND_EOF, 0, p, '0);
         lx_eof = 1'b1;
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
         // whitespace only separates tokens
      end else if (c == CH_SLASH) begin
         lx_mode  = MODE_SLASH;
         lx_start = p;
         lx_len   = 1;
      end else if (c == CH_QUOTE) begin
         lx_mode  = MODE_STRING;
         lx_start = p + 1'b1;
         lx_len   = 0;
      end else if (is_digit(c)) begin
         lx_mode  = MODE_INT;
         lx_start = p;
         lx_len   = 1;
      end else if (c == CH_UNDER || is_letter(c)) begin
         lx_mode    = MODE_IDENT;
         lx_start   = p;
         lx_len     = 1;
         lx_word[0] = c;
      end else if (s >= 0) begin
         add_token(KIND_SYMBOL, s, p, 1);
      end else begin
         add_token(KIND_ERROR, 0, p, 1);
      end
   endfunction

   // tokens closed by one accepted item, appended to expected_tokens
   function automatic void lex_step(req_type item);
      logic [7:0]          c;
      logic [POS_BITS-1:0] p;
      rsp_type             t;
      step_tokens.delete();
      lx_eof = 1'b0;
      if (item.end_of_input) begin
         case (lx_mode)
            MODE_SLASH: add_token(KIND_SYMBOL, int'(SLASH_CODE), lx_start, 1);
            MODE_LINE: add_token(KIND_COMMENT, 0, lx_start, lx_len);
            MODE_BLOCK, MODE_BSTAR, MODE_STRING: add_token(KIND_ERROR, 0, lx_start, lx_len);
            MODE_INT: add_token(KIND_INTEGER, 0, lx_start, lx_len);
            MODE_IDENT: close_word();
            default: ;
         endcase
         add_token(KIND_EOF, 0, lx_pos, '0);
         lx_eof = 1'b1;
      end else begin
         c      = item.char_code;
         p      = lx_pos;
         lx_pos = p + 1'b1;
         case (lx_mode)
            MODE_SLASH: begin
               if (c == CH_SLASH) begin
                  lx_mode = MODE_LINE;
                  lx_len  = 2;
               end else if (c == CH_STAR) begin
                  lx_mode = MODE_BLOCK;
                  lx_len  = 2;
               end else begin
                  add_token(KIND_SYMBOL, int'(SLASH_CODE), lx_start, 1);
                  start_byte(c, p);
               end
            end
            MODE_LINE: begin
               if (c == CH_LF || c == CH_CR || c == CH_NUL) begin
                  add_token(KIND_COMMENT, 0, lx_start, lx_len);
                  start_byte(c, p);
               end else begin
                  grow_lexeme();
               end
            end
            MODE_BLOCK, MODE_BSTAR: begin
               if (c == CH_NUL) begin
                  add_token(KIND_ERROR, 0, lx_start, lx_len);
                  start_byte(c, p);
               end else if (lx_mode == MODE_BSTAR && c == CH_SLASH) begin
                  grow_lexeme();
                  add_token(KIND_COMMENT, 0, lx_start, lx_len);
                  lx_mode = MODE_IDLE;
               end else begin
                  grow_lexeme();
                  lx_mode = (c == CH_STAR) ? MODE_BSTAR : MODE_BLOCK;
               end
            end
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  add_token(KIND_STRING, 0, lx_start, lx_len);
                  lx_mode = MODE_IDLE;
               end else if (c == CH_LF || c == CH_NUL) begin
                  add_token(KIND_ERROR, 0, lx_start, lx_len);
                  start_byte(c, p);
               end else begin
                  grow_lexeme();
               end
            end
            MODE_INT: begin
               if (is_digit(c)) begin
                  grow_lexeme();
               end else begin
                  add_token(KIND_INTEGER, 0, lx_start, lx_len);
                  start_byte(c, p);
               end
            end
            MODE_IDENT: begin
               if (c == CH_UNDER || is_digit(c) || is_letter(c)) begin
                  if (lx_len < WORD_DEPTH) lx_word[lx_len] = c;
                  grow_lexeme();
               end else begin
                  close_word();
                  start_byte(c, p);
               end
            end
            default: start_byte(c, p);
         endcase
      end
      if (lx_eof) lex_clear();
      for (int i = 0; i < step_tokens.size(); i++) begin
         t = step_tokens[i];
         t.last_of_run = (i == step_tokens.size() - 1);
         expected_tokens.insert(expected_tokens.size(), t);
      end
   endfunction

   // stimulus building
   function automatic void push_byte(logic [7:0] c);
      req_type r;
      r.char_code    = c;
      r.end_of_input = 1'b0;
      pending_bytes.insert(pending_bytes.size(), r);
      bytes_queued++;
   endfunction

   function automatic void push_eoi(logic [7:0] junk);
      req_type r;
      r.char_code    = junk;
      r.end_of_input = 1'b1;
      pending_bytes.insert(pending_bytes.size(), r);
      bytes_queued++;
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   function automatic logic [7:0] random_space();
      case ($urandom_range(3))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_LF;
         default: return CH_CR;
      endcase
   endfunction

   function automatic logic [7:0] random_word_char(bit first);
      int r;
      r = first ? $urandom_range(52) : $urandom_range(62);
      if (r < 26) return 8'(CH_A_LO + r);
      if (r < 52) return 8'(CH_A_LO - CH_CASE + r - 26);
      if (r == 52) return CH_UNDER;
      return 8'(CH_0 + r - 53);
   endfunction

   // any byte but NUL and the given terminators
   function automatic logic [7:0] random_content(logic [7:0] stop_a, logic [7:0] stop_b);
      logic [7:0] c;
      do c = 8'($urandom_range(255, 1)); while (c == stop_a || c == stop_b);
      return c;
   endfunction

   function automatic void queue_random_token();
      int         pick;
      int         n;
      logic [7:0] c;
      pick = $urandom_range(99);
      if (pick < 20) begin
         push_text(keyword_names[$urandom_range(KW_NUM - 1)]);
      end else if (pick < 35) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(16, 10) : $urandom_range(8, 1);
         for (int i = 0; i < n; i++) push_byte(random_word_char(i == 0));
      end else if (pick < 45) begin
         n = $urandom_range(6, 1);
         for (int i = 0; i < n; i++) push_byte(8'(CH_0 + $urandom_range(9)));
      end else if (pick < 55) begin
         push_byte(CH_QUOTE);
         n = $urandom_range(8);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) push_byte(CH_CR);
            else push_byte(random_content(CH_QUOTE, CH_LF));
         end
         // a few strings are broken by a newline
         push_byte(($urandom_range(9) == 0) ? CH_LF : CH_QUOTE);
      end else if (pick < 70) begin
         push_byte(symbol_chars[$urandom_range(symbol_chars.len() - 1)]);
      end else if (pick < 75) begin
         push_text("//");
         n = $urandom_range(10);
         for (int i = 0; i < n; i++) push_byte(random_content(CH_LF, CH_CR));
         push_byte($urandom_range(1) ? CH_LF : CH_CR);
      end else if (pick < 80) begin
         push_text("/*");
         n = $urandom_range(10);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
               0: c = CH_STAR;
               1: c = CH_SLASH;
               default: c = random_content(CH_STAR, CH_SLASH);
            endcase
            push_byte(c);
         end
         push_text("*/");
      end else if (pick < 90) begin
         n = $urandom_range(3, 1);
         for (int i = 0; i < n; i++) push_byte(random_space());
      end else if (pick < 96) begin
         push_byte(8'($urandom_range(255)));
      end else if (pick < 98) begin
         push_eoi(8'($urandom_range(255)));
      end else begin
         push_byte(CH_NUL);
      end
      if ($urandom_range(3) != 0) push_byte(random_space());
   endfunction

   // driver: one item offered at a time, prediction taken at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            lex_step(req_payload);
            bytes_accepted <= bytes_accepted + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_payload <= pending_bytes.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls plus one long hold-off to back up the result queue
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && bytes_accepted >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic report_mismatch(string what, rsp_type want, rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: expected kind %0d code %0d start %0d len %0d last %0b,",
                  $realtime, what, want.token_kind, want.token_code, want.token_start,
                  want.token_length, want.last_of_run);
         $display("   got kind %0d code %0d start %0d len %0d last %0b",
                  got.token_kind, got.token_code, got.token_start, got.token_length,
                  got.last_of_run);
      end
   endtask

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_tokens.size() == 0) begin
            report_mismatch("unexpected token", '0, rsp_payload);
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_payload.token_kind !== want.token_kind ||
                rsp_payload.token_code !== want.token_code ||
                rsp_payload.token_start !== want.token_start ||
                rsp_payload.token_length !== want.token_length ||
                rsp_payload.last_of_run !== want.last_of_run) begin
               report_mismatch("token mismatch", want, rsp_payload);
            end
         end
      end
   end

   initial begin
      int target;
      lex_clear();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // keyword, identifier cut by slash, held slash before a digit, integer cut by quote,
      // CR inside a string, string broken by newline, block opener star not closing,
      // unknown bytes, line comment, integer pending at end of input, string cut by byte 0
      push_text("if x1/2\"a");
      push_byte(CH_CR);
      push_text("b");
      push_byte(CH_LF);
      push_text("/*/*/#//c");
      push_byte(CH_LF);
      push_byte(8'hFF);
      push_text("9");
      push_eoi(8'hFF);
      push_text("\"q");
      push_byte(CH_NUL);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 67; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 67; end
            default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
         endcase
         target = bytes_queued + PHASE_BYTES;
         while (bytes_queued < target) queue_random_token();
         while (pending_bytes.size() > 0) @(negedge clock);
      end

      while (req_valid || expected_tokens.size() > 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && expected_tokens.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #(64'd10_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* keyword_symbol_lexer.f */
rtl/ksl_pkg.sv
rtl/keyword_symbol_lexer.sv
rtl/ksl_checker.sv
dv/tb_keyword_symbol_lexer.sv
